// File: sv/mcfq_pkg.sv
// Package for the multi-channel fault qualifier: sizes, codes and beat types.
// No dependencies; used by the interfaces and every module.
package mcfq_pkg;

    localparam int CHANNELS    = 32;
    localparam int SAMPLE_BITS = 24;
    localparam int COUNT_BITS  = 28;
    localparam int FAULT_BITS  = 16;
    localparam int CH_BITS     = 5;
    localparam int ACT_BITS    = 2;
    localparam int MODE_BITS   = 2;
    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [31:0] CNT_CAP = 32'h0FFF_FFFF;
    localparam logic [COUNT_BITS-1:0] COUNT_SAT =
        (COUNT_BITS > 28) ? COUNT_BITS'(CNT_CAP) : {COUNT_BITS{1'b1}};

    localparam logic [ACT_BITS-1:0] ACT_CHECK = ACT_BITS'(0);
    localparam logic [ACT_BITS-1:0] ACT_WRITE = ACT_BITS'(1);
    localparam logic [ACT_BITS-1:0] ACT_CLEAR = ACT_BITS'(2);

    localparam logic [MODE_BITS-1:0] MODE_OVER  = MODE_BITS'(0);
    localparam logic [MODE_BITS-1:0] MODE_UNDER = MODE_BITS'(1);

    typedef struct packed {
        logic [ACT_BITS-1:0]           action;
        logic [CH_BITS-1:0]            channel;
        logic                          pass_start;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [MODE_BITS-1:0]          compare_mode;
        logic signed [SAMPLE_BITS-1:0] trip_level;
        logic signed [SAMPLE_BITS-1:0] release_level;
        logic [COUNT_BITS-1:0]         persist_limit;
        logic [FAULT_BITS-1:0]         fault_mask;
    } t_in_item;

    typedef struct packed {
        logic [FAULT_BITS-1:0] fault_word;
        logic                  tripped;
        logic [COUNT_BITS-1:0] persist_count;
    } t_out_item;

    typedef struct packed {
        logic [MODE_BITS-1:0]          mode;
        logic signed [SAMPLE_BITS-1:0] trip;
        logic signed [SAMPLE_BITS-1:0] rel;
        logic [COUNT_BITS-1:0]         limit;
        logic [FAULT_BITS-1:0]         mask;
    } t_chan_cfg;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic                  trip;
    } t_eval;

endpackage

// File: sv/mcfq_in_if.sv
// Input channel of the fault qualifier: valid/ready with one item per beat.
// Depends on mcfq_pkg.
interface mcfq_in_if;
    import mcfq_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/mcfq_out_if.sv
// Result channel of the fault qualifier: valid/ready with one result per beat.
// Depends on mcfq_pkg.
interface mcfq_out_if;
    import mcfq_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/mcfq_eval.sv
// Per-channel check: trip/release compare, saturating persistence count, trip.
// Depends on mcfq_pkg.
module mcfq_eval (
    input  mcfq_pkg::t_chan_cfg                     i_cfg,
    input  logic [mcfq_pkg::COUNT_BITS-1:0]         i_count,
    input  logic signed [mcfq_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [mcfq_pkg::FAULT_BITS-1:0]         i_faults,
    output mcfq_pkg::t_eval                         o_eval
);
    import mcfq_pkg::*;

    logic                  past;
    logic                  back;
    logic                  active;
    logic [COUNT_BITS:0]   inc;
    logic [COUNT_BITS-1:0] inc_sat;

    always_comb begin
        past   = 1'b0;
        back   = 1'b0;
        active = 1'b0;
        if (i_cfg.mode == MODE_OVER) begin
            past   = i_sample > i_cfg.trip;
            back   = i_sample < i_cfg.rel;
            active = 1'b1;
        end else if (i_cfg.mode == MODE_UNDER) begin
            past   = i_sample < i_cfg.trip;
            back   = i_sample > i_cfg.rel;
            active = 1'b1;
        end
        if ((i_faults & i_cfg.mask) != '0) begin
            active = 1'b0;
        end

        inc     = {1'b0, i_count} + (COUNT_BITS+1)'(1);
        inc_sat = (inc >= {1'b0, COUNT_SAT}) ? COUNT_SAT : inc[COUNT_BITS-1:0];

        o_eval.count = i_count;
        o_eval.trip  = 1'b0;
        if (active && past) begin
            if (inc_sat >= i_cfg.limit) begin
                o_eval.count = '0;
                o_eval.trip  = 1'b1;
            end else begin
                o_eval.count = inc_sat;
            end
        end else if (active && back) begin
            o_eval.count = '0;
        end
    end
endmodule

// File: sv/multi_channel_fault_qualifier.sv
// Top level of the multi-channel fault qualifier: settings and count memories,
// read-modify-write stage with forwarding, result register. Uses mcfq_pkg,
// mcfq_in_if, mcfq_out_if and mcfq_eval.
//
//  port    dir  beat contents
//  i_in    in   action, channel, pass_start, sample, channel settings
//  o_out   out  fault_word, tripped, persist_count
//
// One beat per cycle unless the output stalls; a beat passes stage 1, then the result register.
// Stage 0 reads both memories; stage 1 evaluates and writes the count back,
// forwarding to a following beat on the same channel.
// Reset clears counts (valid bits), fault word and pass block; no sweep.
// A stalled result register holds stage 1, which then holds the input.
module multi_channel_fault_qualifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcfq_in_if.sink     i_in,
    mcfq_out_if.source  o_out
);
    import mcfq_pkg::*;

    t_chan_cfg             r_cfg_mem [CHANNELS];
    logic [COUNT_BITS-1:0] r_cnt_mem [CHANNELS];
    logic [CHANNELS-1:0]   r_cnt_vld;

    t_chan_cfg             r_cfg_rd;
    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic                  r_byp;
    logic [COUNT_BITS-1:0] r_byp_cnt;

    logic                  r_s1_v;
    t_in_item              r_s1;
    logic                  r_o_v;
    t_out_item             r_o;
    logic [FAULT_BITS-1:0] r_faults;
    logic                  r_blocked;

    logic                  in_acc;
    logic                  s1_adv;
    logic [CH_IDX_W-1:0]   in_idx;
    logic                  in_range_in;
    logic [CH_IDX_W-1:0]   s1_idx;
    logic                  s1_range;
    logic                  n_blocked;
    logic                  do_check;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [COUNT_BITS-1:0] cnt_new;
    logic                  trip;
    logic [FAULT_BITS-1:0] n_faults;
    t_chan_cfg             wr_cfg;
    t_eval                 ev;

    assign s1_adv      = r_s1_v && (!r_o_v || o_out.ready);
    assign i_in.ready  = !r_s1_v || s1_adv;
    assign in_acc      = i_in.valid && i_in.ready;
    assign in_idx      = i_in.payload.channel[CH_IDX_W-1:0];
    assign in_range_in = 32'(i_in.payload.channel) < 32'(CHANNELS);
    assign s1_idx      = r_s1.channel[CH_IDX_W-1:0];
    assign s1_range    = 32'(r_s1.channel) < 32'(CHANNELS);

    assign wr_cfg.mode  = i_in.payload.compare_mode;
    assign wr_cfg.trip  = i_in.payload.trip_level;
    assign wr_cfg.rel   = i_in.payload.release_level;
    assign wr_cfg.limit = i_in.payload.persist_limit;
    assign wr_cfg.mask  = i_in.payload.fault_mask;

    // settings memory: written on an accepted in-range write beat, read for every beat
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.payload.action == ACT_WRITE && in_range_in) begin
            r_cfg_mem[in_idx] <= wr_cfg;
        end
        if (in_acc) begin
            r_cfg_rd <= r_cfg_mem[in_idx];
        end
    end

    // count memory: written back from stage 1
    always_ff @(posedge i_clk) begin
        if (s1_adv && do_check) begin
            r_cnt_mem[s1_idx] <= cnt_new;
        end
        if (in_acc) begin
            r_cnt_rd  <= r_cnt_mem[in_idx];
            r_byp_cnt <= cnt_new;
        end
    end

    always_comb begin
        n_blocked = r_blocked;
        if (r_s1.action == ACT_CHECK && r_s1.pass_start) begin
            n_blocked = r_faults != '0;
        end
        do_check = r_s1.action == ACT_CHECK && s1_range && !n_blocked;

        if (r_byp) begin
            cnt_cur = r_byp_cnt;
        end else if (r_cnt_vld[s1_idx]) begin
            cnt_cur = r_cnt_rd;
        end else begin
            cnt_cur = '0;
        end
    end

    mcfq_eval u_eval (
        .i_cfg    (r_cfg_rd),
        .i_count  (cnt_cur),
        .i_sample (r_s1.sample),
        .i_faults (r_faults),
        .o_eval   (ev)
    );

    always_comb begin
        cnt_new  = do_check ? ev.count : cnt_cur;
        trip     = do_check && ev.trip;
        n_faults = r_faults;
        if (r_s1.action == ACT_CLEAR) begin
            n_faults = '0;
        end else if (trip) begin
            n_faults = r_faults | r_cfg_rd.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_o_v     <= 1'b0;
            r_faults  <= '0;
            r_blocked <= 1'b0;
            r_cnt_vld <= '0;
            r_byp     <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_v <= 1'b1;
                r_byp  <= s1_adv && do_check && s1_idx == in_idx;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_o_v     <= 1'b1;
                r_faults  <= n_faults;
                r_blocked <= (r_s1.action == ACT_CHECK) ? n_blocked : r_blocked;
                if (do_check) begin
                    r_cnt_vld[s1_idx] <= 1'b1;
                end
            end else if (o_out.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in.payload;
        end
        if (s1_adv) begin
            r_o.fault_word    <= n_faults;
            r_o.tripped       <= trip;
            r_o.persist_count <= s1_range ? cnt_new : '0;
        end
    end

    assign o_out.valid   = r_o_v;
    assign o_out.payload = r_o;

`ifndef SYNTHESIS
    a_stall_holds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !s1_adv |=> r_s1_v)
        else $error("stage 1 beat lost while stalled");

    a_ready_only_on_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_s1_v && r_o_v)
        else $error("input stalled with room in the pipeline");

    a_trip_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.tripped |-> o_out.payload.persist_count == '0)
        else $error("tripped result with nonzero count");

    a_bypass_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s1_adv && do_check && s1_idx == in_idx |=> r_byp)
        else $error("count forwarding missed after a write-back");
`endif
endmodule
